FILE: hw/rtl/nearest_neighbor_image_scaler_assert.svh
// Assertion macros used by the scaler checker.
`ifndef NEAREST_NEIGHBOR_IMAGE_SCALER_ASSERT_SVH
`define NEAREST_NEIGHBOR_IMAGE_SCALER_ASSERT_SVH

// Same-cycle implication, off while reset is held.
`define NNIS_ASSERT_IMPLY(name, ck, rs, ante, cons) \
    name: assert property (@(posedge ck) disable iff (!(rs)) (ante) |-> (cons)) \
        else $error("scaler assertion failed");

// Next-cycle implication, off while reset is held.
`define NNIS_ASSERT_NEXT(name, ck, rs, ante, cons) \
    name: assert property (@(posedge ck) disable iff (!(rs)) (ante) |=> (cons)) \
        else $error("scaler assertion failed");

`endif

FILE: hw/rtl/nnis_pkg.sv
`timescale 1ns / 1ps

package nnis_pkg;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_SRC_WIDTH  = 2'd0,
        REG_SRC_HEIGHT = 2'd1,
        REG_DST_WIDTH  = 2'd2,
        REG_DST_HEIGHT = 2'd3
    } reg_index_t;

    localparam int CFG_IDX_W = 2;
    localparam int SRC_CFG_W = 9;
    localparam int DST_CFG_W = 10;
    localparam int CFG_DATA_W = 10;
    localparam int COORD_W = 9;
    localparam int ADDR_W = 16;
    localparam int PIX_W = 16;

    // y*src_height and x*src_width, and the linear address built from row/col
    localparam int PROD_W = SRC_CFG_W + COORD_W;
    localparam int LIN_W = PROD_W;
    // quotient is below the source size, so it fits a source dimension
    localparam int QW = SRC_CFG_W;

    localparam logic [SRC_CFG_W-1:0] SRC_WIDTH_RST = 9'd70;
    localparam logic [SRC_CFG_W-1:0] SRC_HEIGHT_RST = 9'd134;
    localparam logic [DST_CFG_W-1:0] DST_WIDTH_RST = 10'd170;
    localparam logic [DST_CFG_W-1:0] DST_HEIGHT_RST = 10'd320;

    // Per-word side data that rides along every stage
    typedef struct packed {
        logic              wr;
        logic              oor;
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0]  pix;
    } side_t;

endpackage

FILE: hw/rtl/nearest_neighbor_image_scaler.sv
`timescale 1ns / 1ps

// Nearest-neighbor scaler for RGB565 images. A word with req_type 0 stores
// pixel_in at src_addr of the on-chip source store (addresses at or beyond
// SRC_DEPTH are dropped); a word with req_type 1 asks for destination pixel
// (dst_x, dst_y) and returns the source pixel at row*src_width + column, with
// row = dst_y*src_height/dst_height and column = dst_x*src_width/dst_width
// (truncating, destination sizes capped at MAX_DST_DIM). A coordinate outside
// the destination returns 0 with out_of_range set. Writes return nothing.
// Throughput is one word per clock on both channels while in_ready is high.
// After acceptance a read passes through one input register, one multiply
// stage, nine restoring-division stages (one quotient bit each, row and
// column side by side), one address multiply-add stage, MOD_N = 19 -
// clog2(SRC_DEPTH) conditional-subtract stages that fold the address into
// the store, one store read stage and the output register, which drives
// out_valid. Writes pass through the same stages so they land on the store in
// order with reads. A two-entry output buffer keeps in_ready high while a
// result waits; in_ready drops only when both entries are full. Registers are
// written through cfg_we/cfg_index/cfg_data and must only change while idle.
// The store has no reset; reading an entry never written returns garbage.
module nearest_neighbor_image_scaler
    import nnis_pkg::*;
#(
    parameter int SRC_DEPTH = 65536,
    parameter int MAX_DST_DIM = 512
) (
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  req_type,
    input  logic [ADDR_W-1:0]     src_addr,
    input  logic [PIX_W-1:0]      pixel_in,
    input  logic [COORD_W-1:0]    dst_x,
    input  logic [COORD_W-1:0]    dst_y,

    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [PIX_W-1:0]      pixel_out,
    output logic                  out_of_range
);

    localparam int AW = $clog2(SRC_DEPTH);
    // clamped destination size width
    localparam int CW = ($clog2(MAX_DST_DIM + 1) > DST_CFG_W) ?
                        $clog2(MAX_DST_DIM + 1) : DST_CFG_W;
    localparam int DIV_STEPS = QW;
    localparam int CMP_W = (CW + QW - 1 > PROD_W) ? CW + QW - 1 : PROD_W;
    localparam int MOD_N = LIN_W - AW + 1;
    localparam int MW = LIN_W + 1;

    // stage positions
    localparam int ST_MUL = 1;
    localparam int ST_DIV0 = 2;
    localparam int ST_ADR = ST_DIV0 + DIV_STEPS;
    localparam int ST_MOD0 = ST_ADR + 1;
    localparam int ST_RD = ST_MOD0 + MOD_N;
    localparam int NS = ST_RD + 1;

    // ---------------- configuration ----------------
    logic [SRC_CFG_W-1:0] src_width_reg;
    logic [SRC_CFG_W-1:0] src_height_reg;
    logic [DST_CFG_W-1:0] dst_width_reg;
    logic [DST_CFG_W-1:0] dst_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= SRC_WIDTH_RST;
            src_height_reg <= SRC_HEIGHT_RST;
            dst_width_reg  <= DST_WIDTH_RST;
            dst_height_reg <= DST_HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            case (reg_index_t'(cfg_index))
                REG_SRC_WIDTH:  src_width_reg  <= cfg_data[SRC_CFG_W-1:0];
                REG_SRC_HEIGHT: src_height_reg <= cfg_data[SRC_CFG_W-1:0];
                REG_DST_WIDTH:  dst_width_reg  <= cfg_data[DST_CFG_W-1:0];
                REG_DST_HEIGHT: dst_height_reg <= cfg_data[DST_CFG_W-1:0];
                default:        ;
            endcase
        end
    end

    // destination sizes capped at MAX_DST_DIM
    logic [CW-1:0] dw_ext;
    logic [CW-1:0] dh_ext;
    logic [CW-1:0] dw_c;
    logic [CW-1:0] dh_c;

    assign dw_ext = CW'(dst_width_reg);
    assign dh_ext = CW'(dst_height_reg);
    assign dw_c = (dw_ext > CW'(MAX_DST_DIM)) ? CW'(MAX_DST_DIM) : dw_ext;
    assign dh_c = (dh_ext > CW'(MAX_DST_DIM)) ? CW'(MAX_DST_DIM) : dh_ext;

    // ---------------- pipeline control ----------------
    // The whole pipe moves together; it halts only when the skid entry is full.
    logic          en;
    logic [NS-1:0] vld_reg;
    logic          skid_vld_reg;

    assign en = !skid_vld_reg;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NS-2:0], in_valid};
        end
    end

    // ---------------- input and multiply stages ----------------
    logic [COORD_W-1:0] x_reg;
    logic [COORD_W-1:0] y_reg;
    logic [PROD_W-1:0]  px_reg;
    logic [PROD_W-1:0]  py_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg  <= dst_x;
            y_reg  <= dst_y;
            px_reg <= PROD_W'(x_reg) * PROD_W'(src_width_reg);
            py_reg <= PROD_W'(y_reg) * PROD_W'(src_height_reg);
        end
    end

    // side data at every stage
    side_t side_reg [NS];
    side_t mul_side;

    // range check joins the side data at the multiply stage
    always_comb
    begin
        mul_side = side_reg[0];
        mul_side.oor = (CW'(x_reg) >= dw_c) || (CW'(y_reg) >= dh_c);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0].wr   <= !req_type;
            side_reg[0].oor  <= 1'b0;
            side_reg[0].addr <= src_addr;
            side_reg[0].pix  <= pixel_in;
            side_reg[ST_MUL] <= mul_side;
            for (int i = ST_MUL + 1; i < NS; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // ---------------- restoring division, one bit per stage ----------------
    logic [PROD_W-1:0] rem_x_reg [DIV_STEPS];
    logic [PROD_W-1:0] rem_y_reg [DIV_STEPS];
    logic [QW-1:0]     q_x_reg [DIV_STEPS];
    logic [QW-1:0]     q_y_reg [DIV_STEPS];

    for (genvar j = 0; j < DIV_STEPS; j++)
    begin : g_div
        localparam int SH = DIV_STEPS - 1 - j;

        logic [PROD_W-1:0] rx_in;
        logic [PROD_W-1:0] ry_in;
        logic [QW-1:0]     qx_in;
        logic [QW-1:0]     qy_in;
        logic [CMP_W-1:0]  tx;
        logic [CMP_W-1:0]  ty;
        logic              gx;
        logic              gy;

        if (j == 0)
        begin : g_first
            assign rx_in = px_reg;
            assign ry_in = py_reg;
            assign qx_in = '0;
            assign qy_in = '0;
        end
        else
        begin : g_next
            assign rx_in = rem_x_reg[j-1];
            assign ry_in = rem_y_reg[j-1];
            assign qx_in = q_x_reg[j-1];
            assign qy_in = q_y_reg[j-1];
        end

        // divisor aligned to this quotient bit
        assign tx = CMP_W'(dw_c) << SH;
        assign ty = CMP_W'(dh_c) << SH;
        assign gx = CMP_W'(rx_in) >= tx;
        assign gy = CMP_W'(ry_in) >= ty;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_x_reg[j] <= gx ? PROD_W'(CMP_W'(rx_in) - tx) : rx_in;
                rem_y_reg[j] <= gy ? PROD_W'(CMP_W'(ry_in) - ty) : ry_in;
                q_x_reg[j]   <= {qx_in[QW-2:0], gx};
                q_y_reg[j]   <= {qy_in[QW-2:0], gy};
            end
        end
    end

    // ---------------- linear address ----------------
    logic [LIN_W-1:0] lin_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lin_reg <= LIN_W'(q_y_reg[DIV_STEPS-1]) * LIN_W'(src_width_reg)
                       + LIN_W'(q_x_reg[DIV_STEPS-1]);
        end
    end

    // ---------------- fold address into the store depth ----------------
    logic [LIN_W-1:0] mod_reg [MOD_N];

    for (genvar k = 0; k < MOD_N; k++)
    begin : g_mod
        localparam int SH = MOD_N - 1 - k;

        logic [LIN_W-1:0] m_in;
        logic [MW-1:0]    mv;
        logic [MW-1:0]    mt;

        if (k == 0)
        begin : g_first
            assign m_in = lin_reg;
        end
        else
        begin : g_next
            assign m_in = mod_reg[k-1];
        end

        assign mv = MW'(m_in);
        assign mt = MW'(SRC_DEPTH) << SH;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                mod_reg[k] <= (mv >= mt) ? LIN_W'(mv - mt) : m_in;
            end
        end
    end

    // ---------------- source store ----------------
    logic [PIX_W-1:0] mem [SRC_DEPTH];
    logic [PIX_W-1:0] rd_data_reg;
    logic [AW-1:0]    rd_idx;
    logic [AW-1:0]    wr_idx;
    logic             wr_in_range;
    side_t            mem_side;

    assign mem_side = side_reg[ST_RD-1];
    assign rd_idx = mod_reg[MOD_N-1][AW-1:0];
    assign wr_idx = mem_side.addr[AW-1:0];
    assign wr_in_range = {1'b0, mem_side.addr} < (ADDR_W + 1)'(SRC_DEPTH);

    // one access per cycle while the pipe moves, in word order
    always_ff @(posedge clk)
    begin
        if (en && vld_reg[ST_RD-1])
        begin
            if (mem_side.wr)
            begin
                if (wr_in_range)
                begin
                    mem[wr_idx] <= mem_side.pix;
                end
            end
            else
            begin
                rd_data_reg <= mem[rd_idx];
            end
        end
    end

    // ---------------- output register and skid entry ----------------
    logic             inc_vld;
    logic [PIX_W-1:0] inc_pix;
    logic             out_vld_reg;
    logic [PIX_W-1:0] out_pix_reg;
    logic             out_oor_reg;
    logic [PIX_W-1:0] skid_pix_reg;
    logic             skid_oor_reg;

    assign inc_vld = vld_reg[ST_RD] && !side_reg[ST_RD].wr;
    assign inc_pix = side_reg[ST_RD].oor ? '0 : rd_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            if (out_vld_reg && !out_ready)
            begin
                skid_vld_reg <= inc_vld;
            end
            else
            begin
                out_vld_reg <= inc_vld;
            end
        end
        else if (out_ready)
        begin
            out_vld_reg  <= 1'b1;
            skid_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (out_vld_reg && !out_ready)
            begin
                skid_pix_reg <= inc_pix;
                skid_oor_reg <= side_reg[ST_RD].oor;
            end
            else
            begin
                out_pix_reg <= inc_pix;
                out_oor_reg <= side_reg[ST_RD].oor;
            end
        end
        else if (out_ready)
        begin
            out_pix_reg <= skid_pix_reg;
            out_oor_reg <= skid_oor_reg;
        end
    end

    assign out_valid = out_vld_reg;
    assign pixel_out = out_pix_reg;
    assign out_of_range = out_oor_reg;

endmodule

FILE: hw/rtl/nnis_checker.sv
`timescale 1ns / 1ps

`include "nearest_neighbor_image_scaler_assert.svh"

module nnis_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] pixel_out,
    input logic        out_of_range
);

    // out-of-range results carry a zero pixel
    `NNIS_ASSERT_IMPLY(a_oor_zero, clk, rst_n, out_valid && out_of_range, pixel_out == 16'd0)

    // a pending word holds until taken
    `NNIS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(pixel_out) && $stable(out_of_range))

    // backpressure only while a result is waiting
    `NNIS_ASSERT_IMPLY(a_stall_has_result, clk, rst_n, !in_ready, out_valid)

    // draining the output frees the skid entry at once
    `NNIS_ASSERT_NEXT(a_stall_clears, clk, rst_n, !in_ready && out_ready, in_ready)

endmodule

bind nearest_neighbor_image_scaler nnis_checker u_nnis_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pixel_out    (pixel_out),
    .out_of_range (out_of_range)
);

FILE: tb/sv/nearest_neighbor_image_scaler_tb.sv
`timescale 1ns / 1ps

module nearest_neighbor_image_scaler_tb;
    import nnis_pkg::*;

    localparam int SRC_DEPTH      = 65536;
    localparam int MAX_DST_DIM    = 512;
    // writes leave no result, so wait DRAIN_CYCLES for the pipeline to drain
    // before touching the size registers
    localparam int DRAIN_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_PHASES  = 10;
    localparam int WORDS_PER_PHASE = 75;

    // one input word as the sender sees it
    typedef struct {
        bit               rd;
        bit [ADDR_W-1:0]  addr;
        bit [PIX_W-1:0]   pix;
        bit [COORD_W-1:0] x;
        bit [COORD_W-1:0] y;
    } scale_req_t;

    // one expected output word; x/y kept for the mismatch report
    typedef struct {
        bit [PIX_W-1:0]   pix;
        bit               oor;
        bit [COORD_W-1:0] x;
        bit [COORD_W-1:0] y;
    } scaled_pix_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic                  req_type = 1'b0;
    logic [ADDR_W-1:0]     src_addr = '0;
    logic [PIX_W-1:0]      pixel_in = '0;
    logic [COORD_W-1:0]    dst_x = '0;
    logic [COORD_W-1:0]    dst_y = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [PIX_W-1:0]      pixel_out;
    logic                  out_of_range;

    nearest_neighbor_image_scaler #(
        .SRC_DEPTH   (SRC_DEPTH),
        .MAX_DST_DIM (MAX_DST_DIM)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .src_addr     (src_addr),
        .pixel_in     (pixel_in),
        .dst_x        (dst_x),
        .dst_y        (dst_y),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pixel_out    (pixel_out),
        .out_of_range (out_of_range)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // predictor's copy of the size registers, reset values from the package
    bit [SRC_CFG_W-1:0] cur_src_w = SRC_WIDTH_RST;
    bit [SRC_CFG_W-1:0] cur_src_h = SRC_HEIGHT_RST;
    bit [DST_CFG_W-1:0] cur_dst_w = DST_WIDTH_RST;
    bit [DST_CFG_W-1:0] cur_dst_h = DST_HEIGHT_RST;

    // predictor's source image; written_map is the generator's view of which
    // entries hold data, so no read ever lands on an unwritten entry
    bit [PIX_W-1:0] src_image [SRC_DEPTH];
    bit             written_map [SRC_DEPTH];

    scale_req_t  pending_words[$];
    scaled_pix_t expected_pixels[$];
    scale_req_t  cur_req;
    scaled_pix_t head_pix;

    logic in_took = 1'b0;   // input word accepted at the last rising edge
    bit   steady = 1'b0;    // no idling on either side while set
    int   in_gap = 0;
    int   ready_hold = 0;
    int   quiet_cycles = 0;
    int   mismatches = 0;

    // Maps a destination coordinate to a source address.
    // Returns 1 when the coordinate is outside the destination.
    function automatic bit nearest_src_addr(input bit [COORD_W-1:0] x,
                                            input bit [COORD_W-1:0] y,
                                            output bit [ADDR_W-1:0] addr);
        int unsigned dw;
        int unsigned dh;
        int unsigned row;
        int unsigned col;
        // destination sizes saturate at the maximum dimension
        dw = (cur_dst_w > MAX_DST_DIM) ? MAX_DST_DIM : cur_dst_w;
        dh = (cur_dst_h > MAX_DST_DIM) ? MAX_DST_DIM : cur_dst_h;
        addr = '0;
        // a zero size makes every coordinate out of range, no division
        if (x >= dw || y >= dh)
            return 1'b1;
        row = (y * cur_src_h) / dh;
        col = (x * cur_src_w) / dw;
        // oversized source sizes wrap around the store
        addr = ADDR_W'((row * cur_src_w + col) % SRC_DEPTH);
        return 1'b0;
    endfunction

    function automatic scaled_pix_t scale_lookup(input scale_req_t r);
        scaled_pix_t res;
        bit [ADDR_W-1:0] a;
        res.x = r.x;
        res.y = r.y;
        res.oor = nearest_src_addr(r.x, r.y, a);
        res.pix = res.oor ? '0 : src_image[a];
        return res;
    endfunction

    // mostly back to back, some short gaps, a few long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 70)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic push_write(input bit [ADDR_W-1:0] addr, input bit [PIX_W-1:0] pix);
        scale_req_t r;
        r.rd = 1'b0;
        r.addr = addr;
        r.pix = pix;
        // coordinates are don't-care on a write; toggle them anyway
        r.x = COORD_W'($urandom);
        r.y = COORD_W'($urandom);
        written_map[addr] = 1'b1;
        pending_words.push_back(r);
    endtask

    // queues a read, preceded by a write when the source entry is still empty
    task automatic push_read(input bit [COORD_W-1:0] x, input bit [COORD_W-1:0] y);
        scale_req_t r;
        bit [ADDR_W-1:0] a;
        if (!nearest_src_addr(x, y, a) && !written_map[a])
            push_write(a, PIX_W'($urandom));
        r.rd = 1'b1;
        r.addr = ADDR_W'($urandom);
        r.pix = PIX_W'($urandom);
        r.x = x;
        r.y = y;
        pending_words.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input scaled_pix_t e);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s at (%0d,%0d): expected pixel %h oor %b, got pixel %h oor %b",
                     $realtime, what, e.x, e.y, e.pix, e.oor, pixel_out, out_of_range);
    endtask

    // Sender: a new word goes out at a falling edge once the last one was taken
    // and any gap has run out; in_valid gets at most one assignment per edge.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_took)
            begin
                if (in_gap > 0)
                begin
                    in_gap <= in_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_words.size() > 0)
                begin
                    cur_req = pending_words.pop_front();
                    req_type <= cur_req.rd;
                    src_addr <= cur_req.addr;
                    pixel_in <= cur_req.pix;
                    dst_x <= cur_req.x;
                    dst_y <= cur_req.y;
                    in_valid <= 1'b1;
                    in_gap <= gap_len();
                end
                else
                    in_valid <= 1'b0;
            end

            // receiver: runs of ready broken by stalls of random length
            if (steady)
            begin
                out_ready <= 1'b1;
                ready_hold <= 0;
            end
            else if (ready_hold > 0)
                ready_hold <= ready_hold - 1;
            else if ($urandom_range(0, 2) == 0)
            begin
                out_ready <= 1'b0;
                ready_hold <= gap_len();
            end
            else
            begin
                out_ready <= 1'b1;
                ready_hold <= $urandom_range(0, 15);
            end
        end
    end

    // Rising edge: check results, predict accepted words, watchdog.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    head_pix = '{pix: '0, oor: 1'b0, x: '0, y: '0};
                    report_mismatch("unexpected word", head_pix);
                end
                else
                begin
                    head_pix = expected_pixels.pop_front();
                    if (pixel_out !== head_pix.pix || out_of_range !== head_pix.oor)
                        report_mismatch("mismatch", head_pix);
                end
            end

            // the store updates in word order, same as the pipeline
            if (in_valid && in_ready)
            begin
                if (cur_req.rd)
                    expected_pixels.push_back(scale_lookup(cur_req));
                else
                    src_image[cur_req.addr] = cur_req.pix;
            end
            in_took <= in_valid && in_ready;

            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // sender pauses until every result is back and the pipe has drained
    task automatic wait_idle();
        while (pending_words.size() != 0 || in_valid || expected_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic apply_sizes(input bit [CFG_DATA_W-1:0] sw, input bit [CFG_DATA_W-1:0] sh,
                               input bit [CFG_DATA_W-1:0] dw, input bit [CFG_DATA_W-1:0] dh);
        bit [CFG_DATA_W-1:0] vals [4];
        int i;
        vals = '{sw, sh, dw, dh};
        for (i = 0; i < 4; i++)
        begin
            @(negedge clk);
            cfg_we <= 1'b1;
            cfg_index <= reg_index_t'(i);
            cfg_data <= vals[i];
            // source registers are 9 bits wide, bit 9 is dropped
            case (reg_index_t'(i))
                REG_SRC_WIDTH:  cur_src_w = vals[i][SRC_CFG_W-1:0];
                REG_SRC_HEIGHT: cur_src_h = vals[i][SRC_CFG_W-1:0];
                REG_DST_WIDTH:  cur_dst_w = vals[i];
                REG_DST_HEIGHT: cur_dst_h = vals[i];
                default: ;
            endcase
        end
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Random words: mostly reads inside the destination (preceded by a fill
    // of the source entry when needed), some writes anywhere in the store,
    // some reads at arbitrary coordinates that mostly fall out of range.
    task automatic run_random(input int n);
        int k;
        int r;
        int dw;
        int dh;
        bit [PIX_W-1:0] p;
        dw = (cur_dst_w > MAX_DST_DIM) ? MAX_DST_DIM : cur_dst_w;
        dh = (cur_dst_h > MAX_DST_DIM) ? MAX_DST_DIM : cur_dst_h;
        for (k = 0; k < n; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 30)
            begin
                p = PIX_W'($urandom);
                if ($urandom_range(0, 9) == 0)
                    p = $urandom_range(0, 1) ? '1 : '0;
                push_write(ADDR_W'($urandom), p);
            end
            else if (r < 85 && dw > 0 && dh > 0)
                push_read(COORD_W'($urandom_range(0, dw - 1)),
                          COORD_W'($urandom_range(0, dh - 1)));
            else
                push_read(COORD_W'($urandom), COORD_W'($urandom));
        end
    endtask

    initial
    begin
        int p;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed words at reset sizes: 70x134 source, 170x320 destination.
        push_write(16'h0000, 16'hFFFF);
        push_write(16'hFFFF, 16'h0000);
        push_read(0, 0);
        // last in-range pixel maps to row 133, col 69, address 9379;
        // write, read, overwrite, read checks store ordering
        push_write(16'd9379, 16'hA5A5);
        push_read(169, 319);
        push_write(16'd9379, 16'h5A5A);
        push_read(169, 319);
        // just outside in x, in y, and both at the coordinate maximum
        push_read(170, 0);
        push_read(0, 320);
        push_read(511, 511);
        push_read(169, 0);
        push_read(0, 319);
        push_read(85, 160);
        push_write(16'h8000, 16'h7BEF);
        push_read(1, 1);
        run_random(WORDS_PER_PHASE);

        for (p = 1; p <= RANDOM_PHASES; p++)
        begin
            wait_idle();
            case (p)
                1: apply_sizes(1, 1, 1, 1);
                2: apply_sizes(256, 256, 512, 512);
                // zero source sizes, destination above the cap
                3: apply_sizes(0, 0, 1023, 1023);
                // oversized source, addresses wrap around the store
                4: apply_sizes(511, 300, 600, 37);
                // zero destination width: everything out of range
                5: apply_sizes(40, 30, 0, 5);
                8: apply_sizes(CFG_DATA_W'($urandom_range(0, 1023)),
                               CFG_DATA_W'($urandom_range(0, 1023)),
                               CFG_DATA_W'($urandom_range(0, 1023)),
                               CFG_DATA_W'($urandom_range(0, 1023)));
                9: apply_sizes(256, 1, 1, 512);
                default: apply_sizes(CFG_DATA_W'($urandom_range(1, 64)),
                                     CFG_DATA_W'($urandom_range(1, 64)),
                                     CFG_DATA_W'($urandom_range(1, 512)),
                                     CFG_DATA_W'($urandom_range(1, 512)));
            endcase
            steady = (p == 3 || p == 7);
            run_random(WORDS_PER_PHASE);
        end

        wait_idle();
        if (mismatches == 0 && expected_pixels.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/nnis_pkg.sv
hw/rtl/nearest_neighbor_image_scaler.sv
hw/rtl/nnis_checker.sv
tb/sv/nearest_neighbor_image_scaler_tb.sv
